### rtl/mvna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvna_pkg
// Shared constants and types for the mesh vertex normal accumulator.
// ----------------------------------------------------------------------------
package mvna_pkg;

    localparam int NUM_VERTICES_DEF = 1024;

    localparam int IDX_W  = 10;   // vertex index field
    localparam int POS_W  = 24;   // Q12.12 position component
    localparam int SUM_W  = 24;   // Q9.15 sum component
    localparam int NRM_W  = 16;   // Q1.15 normal component
    localparam int DIF_W  = 25;   // edge vector component
    localparam int CRS_W  = 51;   // cross product component
    localparam int MAG_W  = 52;   // magnitude in the normalizer
    localparam int MUL_W  = 31;   // multiplier operand
    localparam int PRD_W  = 62;   // multiplier product
    localparam int LEN_W  = 31;   // vector length
    localparam int QUO_W  = 17;   // division quotient
    localparam int NUM_W  = 46;   // division numerator
    localparam int REM_W  = 32;   // division remainder

    localparam logic [QUO_W-1:0] Q_ONE = 17'd32768;
    localparam logic [QUO_W-1:0] Q_MAX = 17'd32767;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS0,
        ST_POS1,
        ST_POS2,
        ST_POS3,
        ST_DIFF,
        ST_CROSS,
        ST_SUMRD,
        ST_SUMLD,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_ACCRD,
        ST_ACCWR,
        ST_RESULT
    } state_t;

endpackage
`default_nettype wire

### rtl/mesh_vertex_normal_accumulator.sv
`default_nettype none
// Adding a triangle or reading a normal takes time set by the one-bit-per-cycle
// normalize shift, the 31-step square root and the three 17-step divisions on one
// shared divider; a flat face or a zero sum skips the root and the divisions, and an
// out-of-range read goes straight to the result, which may wait on m_ready. One word
// is in work at a time. After reset the sum store is cleared one entry per cycle with
// s_ready low. The result register lets the next word in while a result waits.
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Per-vertex sums of unit face normals, kept in two memories with one write and one read port each.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator #(
    parameter int NUM_VERTICES = mvna_pkg::NUM_VERTICES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_opcode,
    input  wire logic [mvna_pkg::IDX_W-1:0]  s_vertex_a,
    input  wire logic [mvna_pkg::IDX_W-1:0]  s_vertex_b,
    input  wire logic [mvna_pkg::IDX_W-1:0]  s_vertex_c,
    input  wire logic signed [mvna_pkg::POS_W-1:0] s_pos_x,
    input  wire logic signed [mvna_pkg::POS_W-1:0] s_pos_y,
    input  wire logic signed [mvna_pkg::POS_W-1:0] s_pos_z,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mvna_pkg::IDX_W-1:0]       m_vertex_index,
    output logic signed [mvna_pkg::NRM_W-1:0] m_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0] m_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0] m_normal_z,
    output logic                             m_zero_length
);

    localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int IDX_W = mvna_pkg::IDX_W;
    localparam int POS_W = mvna_pkg::POS_W;
    localparam int SUM_W = mvna_pkg::SUM_W;
    localparam int NRM_W = mvna_pkg::NRM_W;
    localparam int DIF_W = mvna_pkg::DIF_W;
    localparam int CRS_W = mvna_pkg::CRS_W;
    localparam int MAG_W = mvna_pkg::MAG_W;
    localparam int MUL_W = mvna_pkg::MUL_W;
    localparam int PRD_W = mvna_pkg::PRD_W;
    localparam int LEN_W = mvna_pkg::LEN_W;
    localparam int QUO_W = mvna_pkg::QUO_W;
    localparam int NUM_W = mvna_pkg::NUM_W;
    localparam int REM_W = mvna_pkg::REM_W;

    // memories
    logic [3*POS_W-1:0] pos_mem [NUM_VERTICES];
    logic [3*SUM_W-1:0] sum_mem [NUM_VERTICES];
    logic [3*POS_W-1:0] pos_rdata_reg;
    logic [3*SUM_W-1:0] sum_rdata_reg;

    logic               pos_we;
    logic [AW-1:0]      pos_waddr;
    logic [AW-1:0]      pos_raddr;
    logic               sum_we;
    logic [AW-1:0]      sum_waddr;
    logic [3*SUM_W-1:0] sum_wdata;
    logic [AW-1:0]      sum_raddr;

    // control
    mvna_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic             m_valid_reg;
    logic             s_fire;
    logic             out_free;

    // item
    logic [1:0]       op_reg;
    logic [IDX_W-1:0] va_reg, vb_reg, vc_reg;
    logic [1:0]       ai_reg;
    logic             va_ok, vb_ok, vc_ok;
    logic             b_dist, c_dist;
    logic [AW-1:0]    a_addr, b_addr, c_addr, corner_addr;

    // datapath
    logic signed [POS_W-1:0] p0_reg [3];
    logic signed [POS_W-1:0] p1_reg [3];
    logic signed [POS_W-1:0] p2_reg [3];
    logic signed [DIF_W-1:0] d1_reg [3];
    logic signed [DIF_W-1:0] d2_reg [3];
    logic signed [CRS_W-1:0] cr_reg [3];
    logic signed [CRS_W-1:0] tmp_reg;
    logic [2:0]              cnt_reg;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] prod;
    logic signed [PRD_W-1:0] prod_reg;

    logic signed [MAG_W-1:0] norm_in [3];
    logic                    norm_load;
    logic [MAG_W-1:0]        mag_reg [3];
    logic                    neg_reg [3];
    logic                    mag_hi, mag_lo, mag_zero;
    logic [1:0]              msel;

    logic [PRD_W-1:0]        sq_reg;
    logic [PRD_W-1:0]        res_reg;
    logic [PRD_W-1:0]        bit_reg;
    logic [PRD_W-1:0]        rb_sum;
    logic [PRD_W-1:0]        res_next;
    logic [LEN_W-1:0]        len_reg;

    logic [1:0]              ci_reg;
    logic [4:0]              dstep_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        q_reg;
    logic [NUM_W-1:0]        div_num;
    logic [QUO_W-1:0]        num_low;
    logic [REM_W-1:0]        div_t;
    logic                    div_ge;
    logic [QUO_W-1:0]        q_next;
    logic [QUO_W-1:0]        q_sat;
    logic signed [NRM_W-1:0] n_fin;

    logic signed [NRM_W-1:0] n_reg [3];
    logic                    zero_reg;
    logic [3*SUM_W-1:0]      acc_word;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    assign va_ok = 32'(s_vertex_a) < NUM_VERTICES;
    assign vb_ok = 32'(s_vertex_b) < NUM_VERTICES;
    assign vc_ok = 32'(s_vertex_c) < NUM_VERTICES;

    assign a_addr = AW'(va_reg);
    assign b_addr = AW'(vb_reg);
    assign c_addr = AW'(vc_reg);
    assign b_dist = vb_reg != va_reg;
    assign c_dist = (vc_reg != va_reg) && (vc_reg != vb_reg);

    always_comb begin
        case (ai_reg)
            2'd1:    corner_addr = b_addr;
            2'd2:    corner_addr = c_addr;
            default: corner_addr = a_addr;
        endcase
    end

    // ------------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= {s_pos_z, s_pos_y, s_pos_x};
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    // ------------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------------
    assign msel = (cnt_reg[1:0] == 2'd3) ? 2'd2 : cnt_reg[1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == mvna_pkg::ST_SQ) begin
            mul_a = {1'b0, mag_reg[msel][29:0]};
            mul_b = {1'b0, mag_reg[msel][29:0]};
        end else begin
            case (cnt_reg)
                3'd0: begin mul_a = MUL_W'(d1_reg[1]); mul_b = MUL_W'(d2_reg[2]); end
                3'd1: begin mul_a = MUL_W'(d1_reg[2]); mul_b = MUL_W'(d2_reg[1]); end
                3'd2: begin mul_a = MUL_W'(d1_reg[2]); mul_b = MUL_W'(d2_reg[0]); end
                3'd3: begin mul_a = MUL_W'(d1_reg[0]); mul_b = MUL_W'(d2_reg[2]); end
                3'd4: begin mul_a = MUL_W'(d1_reg[0]); mul_b = MUL_W'(d2_reg[1]); end
                3'd5: begin mul_a = MUL_W'(d1_reg[1]); mul_b = MUL_W'(d2_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    // ------------------------------------------------------------------------
    // normalizer helpers
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (state_reg == mvna_pkg::ST_SUMLD) begin
                norm_in[i] = MAG_W'($signed(sum_rdata_reg[i*SUM_W +: SUM_W]));
            end else begin
                norm_in[i] = MAG_W'(cr_reg[i]);
            end
        end
    end

    assign norm_load = (state_reg == mvna_pkg::ST_SUMLD) ||
                       (state_reg == mvna_pkg::ST_CROSS && cnt_reg == 3'd7);

    assign mag_hi   = |{mag_reg[0][MAG_W-1:30], mag_reg[1][MAG_W-1:30],
                        mag_reg[2][MAG_W-1:30]};
    assign mag_lo   = ~|{mag_reg[0][MAG_W-1:29], mag_reg[1][MAG_W-1:29],
                         mag_reg[2][MAG_W-1:29]};
    assign mag_zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);

    // square root, one result bit per cycle
    assign rb_sum   = res_reg + bit_reg;
    assign res_next = (sq_reg >= rb_sum) ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    // restoring division, (mag * 32768 + len / 2) / len
    assign div_num = {mag_reg[ci_reg == 2'd3 ? 2'd2 : ci_reg][29:0], 15'd0}
                     + NUM_W'(len_reg[LEN_W-1:1]);
    assign num_low = div_num[QUO_W-1:0];
    assign div_t   = {rem_reg[REM_W-2:0], num_low[dstep_reg]};
    assign div_ge  = div_t >= REM_W'(len_reg);
    assign q_next  = {q_reg[QUO_W-2:0], div_ge};
    assign q_sat   = (q_next > mvna_pkg::Q_ONE) ? mvna_pkg::Q_ONE : q_next;

    always_comb begin
        if (neg_reg[ci_reg == 2'd3 ? 2'd2 : ci_reg]) begin
            n_fin = NRM_W'(QUO_W'(0) - q_sat);
        end else if (q_sat > mvna_pkg::Q_MAX) begin
            n_fin = NRM_W'(mvna_pkg::Q_MAX);
        end else begin
            n_fin = NRM_W'(q_sat);
        end
    end

    // saturating add of the face normal to a stored sum
    always_comb begin
        logic signed [SUM_W:0] s;
        for (int i = 0; i < 3; i++) begin
            s = (SUM_W+1)'($signed(sum_rdata_reg[i*SUM_W +: SUM_W])) +
                (SUM_W+1)'(n_reg[i]);
            if (s[SUM_W] != s[SUM_W-1]) begin
                acc_word[i*SUM_W +: SUM_W] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                      : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                acc_word[i*SUM_W +: SUM_W] = s[SUM_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // next state and memory control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        pos_we     = 1'b0;
        pos_waddr  = AW'(s_vertex_a);
        pos_raddr  = a_addr;
        sum_we     = 1'b0;
        sum_waddr  = AW'(s_vertex_a);
        sum_wdata  = '0;
        sum_raddr  = a_addr;
        case (state_reg)
            mvna_pkg::ST_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(NUM_VERTICES - 1)) begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            mvna_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_opcode)
                        mvna_pkg::OP_LOAD: begin
                            pos_we = va_ok;
                            sum_we = va_ok;
                        end
                        mvna_pkg::OP_ADD: begin
                            if (va_ok && vb_ok && vc_ok) begin
                                state_next = mvna_pkg::ST_POS0;
                            end
                        end
                        mvna_pkg::OP_READ: begin
                            state_next = va_ok ? mvna_pkg::ST_SUMRD : mvna_pkg::ST_RESULT;
                        end
                        default: state_next = mvna_pkg::ST_IDLE;
                    endcase
                end
            end
            mvna_pkg::ST_POS0: begin
                pos_raddr  = a_addr;
                state_next = mvna_pkg::ST_POS1;
            end
            mvna_pkg::ST_POS1: begin
                pos_raddr  = b_addr;
                state_next = mvna_pkg::ST_POS2;
            end
            mvna_pkg::ST_POS2: begin
                pos_raddr  = c_addr;
                state_next = mvna_pkg::ST_POS3;
            end
            mvna_pkg::ST_POS3:  state_next = mvna_pkg::ST_DIFF;
            mvna_pkg::ST_DIFF:  state_next = mvna_pkg::ST_CROSS;
            mvna_pkg::ST_CROSS: begin
                if (cnt_reg == 3'd7) begin
                    state_next = mvna_pkg::ST_NORM;
                end
            end
            mvna_pkg::ST_SUMRD: begin
                sum_raddr  = a_addr;
                state_next = mvna_pkg::ST_SUMLD;
            end
            mvna_pkg::ST_SUMLD: state_next = mvna_pkg::ST_NORM;
            mvna_pkg::ST_NORM: begin
                if (mag_zero) begin
                    state_next = (op_reg == mvna_pkg::OP_ADD) ? mvna_pkg::ST_ACCRD
                                                              : mvna_pkg::ST_RESULT;
                end else if (!mag_hi && !mag_lo) begin
                    state_next = mvna_pkg::ST_SQ;
                end
            end
            mvna_pkg::ST_SQ: begin
                if (cnt_reg == 3'd3) begin
                    state_next = mvna_pkg::ST_SQRT;
                end
            end
            mvna_pkg::ST_SQRT: begin
                if (bit_reg == PRD_W'(1)) begin
                    state_next = mvna_pkg::ST_DINIT;
                end
            end
            mvna_pkg::ST_DINIT: state_next = mvna_pkg::ST_DIV;
            mvna_pkg::ST_DIV: begin
                if (dstep_reg == 5'd0) begin
                    if (ci_reg == 2'd2) begin
                        state_next = (op_reg == mvna_pkg::OP_ADD) ? mvna_pkg::ST_ACCRD
                                                                  : mvna_pkg::ST_RESULT;
                    end else begin
                        state_next = mvna_pkg::ST_DINIT;
                    end
                end
            end
            mvna_pkg::ST_ACCRD: begin
                sum_raddr  = corner_addr;
                state_next = mvna_pkg::ST_ACCWR;
            end
            mvna_pkg::ST_ACCWR: begin
                sum_we    = 1'b1;
                sum_waddr = corner_addr;
                sum_wdata = acc_word;
                // each distinct corner gets the face normal once
                if (ai_reg == 2'd0 && b_dist) begin
                    state_next = mvna_pkg::ST_ACCRD;
                end else if (ai_reg != 2'd2 && c_dist) begin
                    state_next = mvna_pkg::ST_ACCRD;
                end else begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            mvna_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            default: state_next = mvna_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mvna_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mvna_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == mvna_pkg::ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            mvna_pkg::ST_IDLE: begin
                if (s_fire) begin
                    op_reg   <= s_opcode;
                    va_reg   <= s_vertex_a;
                    vb_reg   <= s_vertex_b;
                    vc_reg   <= s_vertex_c;
                    ai_reg   <= 2'd0;
                    zero_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_reg[i] <= '0;
                    end
                end
            end
            mvna_pkg::ST_POS1: begin
                for (int i = 0; i < 3; i++) begin
                    p0_reg[i] <= pos_rdata_reg[i*POS_W +: POS_W];
                end
            end
            mvna_pkg::ST_POS2: begin
                for (int i = 0; i < 3; i++) begin
                    p1_reg[i] <= pos_rdata_reg[i*POS_W +: POS_W];
                end
            end
            mvna_pkg::ST_POS3: begin
                for (int i = 0; i < 3; i++) begin
                    p2_reg[i] <= pos_rdata_reg[i*POS_W +: POS_W];
                end
            end
            mvna_pkg::ST_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    d1_reg[i] <= DIF_W'(p1_reg[i]) - DIF_W'(p0_reg[i]);
                    d2_reg[i] <= DIF_W'(p2_reg[i]) - DIF_W'(p0_reg[i]);
                end
                cnt_reg <= 3'd0;
            end
            mvna_pkg::ST_CROSS: begin
                prod_reg <= prod;
                cnt_reg  <= cnt_reg + 3'd1;
                // products arrive in the cycle after they are formed, in pairs
                if (cnt_reg[0] && cnt_reg != 3'd7) begin
                    tmp_reg <= prod_reg[CRS_W-1:0];
                end else if (cnt_reg != 3'd0 && !cnt_reg[0]) begin
                    cr_reg[cnt_reg[2:1] - 2'd1] <= tmp_reg - prod_reg[CRS_W-1:0];
                end
            end
            mvna_pkg::ST_SUMLD: begin
                cnt_reg <= 3'd0;
            end
            mvna_pkg::ST_NORM: begin
                if (mag_zero) begin
                    zero_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_reg[i] <= '0;
                    end
                end else if (mag_hi) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end else if (mag_lo) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end else begin
                    sq_reg  <= '0;
                    cnt_reg <= 3'd0;
                end
            end
            mvna_pkg::ST_SQ: begin
                prod_reg <= prod;
                cnt_reg  <= cnt_reg + 3'd1;
                if (cnt_reg != 3'd0) begin
                    sq_reg <= sq_reg + prod_reg;
                end
                if (cnt_reg == 3'd3) begin
                    res_reg <= '0;
                    bit_reg <= PRD_W'(1) << 60;
                end
            end
            mvna_pkg::ST_SQRT: begin
                if (sq_reg >= rb_sum) begin
                    sq_reg <= sq_reg - rb_sum;
                end
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                if (bit_reg == PRD_W'(1)) begin
                    len_reg <= res_next[LEN_W-1:0];
                    ci_reg  <= 2'd0;
                end
            end
            mvna_pkg::ST_DINIT: begin
                rem_reg   <= REM_W'(div_num[NUM_W-1:QUO_W]);
                q_reg     <= '0;
                dstep_reg <= 5'(QUO_W - 1);
            end
            mvna_pkg::ST_DIV: begin
                rem_reg   <= div_ge ? (div_t - REM_W'(len_reg)) : div_t;
                q_reg     <= q_next;
                dstep_reg <= dstep_reg - 5'd1;
                if (dstep_reg == 5'd0) begin
                    n_reg[ci_reg == 2'd3 ? 2'd2 : ci_reg] <= n_fin;
                    ci_reg <= ci_reg + 2'd1;
                end
            end
            mvna_pkg::ST_ACCWR: begin
                if (ai_reg == 2'd0 && b_dist) begin
                    ai_reg <= 2'd1;
                end else begin
                    ai_reg <= 2'd2;
                end
            end
            mvna_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_vertex_index <= va_reg;
                    m_normal_x     <= n_reg[0];
                    m_normal_y     <= n_reg[1];
                    m_normal_z     <= n_reg[2];
                    m_zero_length  <= zero_reg;
                end
            end
            default: begin
            end
        endcase

        if (norm_load) begin
            zero_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= norm_in[i][MAG_W-1];
                mag_reg[i] <= norm_in[i][MAG_W-1] ? MAG_W'(-norm_in[i]) : MAG_W'(norm_in[i]);
            end
        end
    end

endmodule
`default_nettype wire
